@@ rtl/assert_macros.svh @@
// Assertion macros shared by the ordered array engine RTL.
// No dependencies; clocked on clk, disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge.
`define OAE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OAE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define OAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/oae_pkg.sv @@
// Shared types and codes for the ordered array engine.
// No dependencies.
`timescale 1ns / 1ps

package oae_pkg;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 9;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [STAT_W-1:0]        status_t;

  localparam req_t REQ_APPEND = 3'd0;
  localparam req_t REQ_INSERT = 3'd1;
  localparam req_t REQ_DELETE = 3'd2;
  localparam req_t REQ_FIND   = 3'd3;
  localparam req_t REQ_READ   = 3'd4;
  localparam req_t REQ_WRITE  = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

@@ rtl/oae_ram.sv @@
// Simple dual-port entry store: one write port, one registered read port.
// Depends on oae_pkg for the word type.
`timescale 1ns / 1ps

module oae_ram #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output oae_pkg::word_t             rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  oae_pkg::word_t             wr_data
);
  import oae_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ordered_array_engine_core.sv @@
// Ordered array engine top level: request sequencer around the entry store.
// Depends on oae_pkg, oae_ram and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   A request (req_type, position, value) transfers at a rising edge with
//   start high and busy low. busy stays high through the done cycle.
//   The result (read_value, found_index, item_count, status) is valid for
//   exactly one cycle while done is high; the receiver cannot stall it.
// Sequencing, accept edge to done cycle:
//   append, write, rejected requests, unused codes, insert at the count,
//   delete of the last entry and find on an empty store go straight to
//   the done state. read, delete and find scan the store and then go to
//   done; insert scans, writes the new value in a final state, then goes
//   to done. The store's single read port paces every scan: shifts and
//   searches move one entry per cycle. busy drops the cycle after done,
//   so the next request may transfer then.
// Reset: the live count clears to zero. Entry contents are not cleared;
//   only entries below the count are ever read.

module ordered_array_engine_core #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  oae_pkg::req_t     req_type,
  input  oae_pkg::pos_t     position,
  input  oae_pkg::word_t    value,
  output logic              done,
  output oae_pkg::word_t    read_value,
  output oae_pkg::pos_t     found_index,
  output oae_pkg::pos_t     item_count,
  output oae_pkg::status_t  status
);
  import oae_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  req_t          op;
  logic [AW-1:0] pos_r;
  word_t         val_r;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] scan_end;
  logic          issue_done;
  logic          pend;
  logic          pend_last;
  logic [CW-1:0] pend_idx;
  logic [AW-1:0] pend_wa;
  word_t         res_rd;
  logic [CW-1:0] res_found;
  status_t       res_status;

  logic          accept;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic          full;
  logic          range_ins;
  logic          range_idx;
  logic [AW-1:0] pos_addr;
  logic          is_ins;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  word_t         rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  word_t         wr_data;

  logic [PW-1:0] found_ext;
  logic [PW-1:0] count_ext;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign pos_ext   = PW'(position);
  assign cnt_ext   = PW'(count);
  assign full      = (count == CW'(DEPTH));
  assign range_ins = (pos_ext > cnt_ext);
  assign range_idx = (pos_ext >= cnt_ext);
  assign pos_addr  = AW'(position);
  assign is_ins    = (op == REQ_INSERT);

  // Shift writes target an entry behind the scan, never the one read now.
  assign rd_en   = (state == S_SCAN) && !issue_done;
  assign rd_addr = rd_ptr[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_wa;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_APPEND && !full) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count);
            wr_data = value;
          end else if (req_type == REQ_INSERT && !range_ins && !full
                       && pos_ext == cnt_ext) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count);
            wr_data = value;
          end else if (req_type == REQ_WRITE && !range_idx) begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = value;
          end
        end
      end
      S_SCAN: begin
        wr_en = pend && (op == REQ_INSERT || op == REQ_DELETE);
      end
      S_FINAL: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = val_r;
      end
      S_DONE: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req_type;
            val_r      <= value;
            pos_r      <= pos_addr;
            res_rd     <= '0;
            res_found  <= '0;
            res_status <= ST_OK;
            issue_done <= 1'b0;
            pend       <= 1'b0;
            pend_last  <= 1'b0;
            state      <= S_DONE;
            case (req_type)
              REQ_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              REQ_INSERT: begin
                if (range_ins) begin
                  res_status <= ST_RANGE;
                end else if (full) begin
                  res_status <= ST_FULL;
                end else if (pos_ext == cnt_ext) begin
                  count <= count + CW'(1);
                end else begin
                  rd_ptr   <= count - CW'(1);
                  scan_end <= CW'(position);
                  state    <= S_SCAN;
                end
              end
              REQ_DELETE: begin
                if (range_idx) begin
                  res_status <= ST_RANGE;
                end else if (pos_ext + PW'(1) == cnt_ext) begin
                  count <= count - CW'(1);
                end else begin
                  rd_ptr   <= CW'(position) + CW'(1);
                  scan_end <= count - CW'(1);
                  state    <= S_SCAN;
                end
              end
              REQ_FIND: begin
                if (count != '0) begin
                  rd_ptr   <= '0;
                  scan_end <= count - CW'(1);
                  state    <= S_SCAN;
                end
              end
              REQ_READ: begin
                if (range_idx) begin
                  res_status <= ST_RANGE;
                end else begin
                  rd_ptr   <= CW'(position);
                  scan_end <= CW'(position);
                  state    <= S_SCAN;
                end
              end
              REQ_WRITE: begin
                if (range_idx) begin
                  res_status <= ST_RANGE;
                end
              end
              default: begin
                res_status <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            pend      <= 1'b1;
            pend_idx  <= rd_ptr;
            pend_wa   <= is_ins ? AW'(rd_ptr + CW'(1)) : AW'(rd_ptr - CW'(1));
            pend_last <= (rd_ptr == scan_end);
            if (rd_ptr == scan_end) begin
              issue_done <= 1'b1;
            end else begin
              rd_ptr <= is_ins ? rd_ptr - CW'(1) : rd_ptr + CW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            case (op)
              REQ_FIND: begin
                if (rd_data == val_r) begin
                  res_found <= pend_idx;
                  state     <= S_DONE;
                end else if (pend_last) begin
                  res_found <= count;
                  state     <= S_DONE;
                end
              end
              REQ_READ: begin
                res_rd <= rd_data;
                state  <= S_DONE;
              end
              REQ_INSERT: begin
                if (pend_last) begin
                  state <= S_FINAL;
                end
              end
              REQ_DELETE: begin
                if (pend_last) begin
                  count <= count - CW'(1);
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FINAL: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  oae_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign found_ext   = PW'(res_found);
  assign count_ext   = PW'(count);
  assign done        = (state == S_DONE);
  assign read_value  = res_rd;
  assign found_index = found_ext[POS_W-1:0];
  assign item_count  = count_ext[POS_W-1:0];
  assign status      = res_status;

  `OAE_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "live count exceeds depth")
  `OAE_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
  `OAE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `OAE_ASSERT_IMPLY(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr,
                    "read and write of the same entry in one cycle")

endmodule
